### rtl/qmlp_pkg.sv
// ----------------------------------------------------------------------------
// qmlp_pkg
// Shared types and constants for the quantized 8-8-4-1 network evaluator.
// ----------------------------------------------------------------------------
package qmlp_pkg;

    localparam int SUM_BITS  = 20;
    localparam int N_HID1    = 8;
    localparam int N_HID2    = 4;
    localparam int ACT_SHIFT = 6;
    localparam int ACT_MAX   = 127;
    localparam int L2_BITS   = 24;
    localparam int OUT_BITS  = 24;

    localparam logic [2:0] REG_HB_LO = 3'd0;
    localparam logic [2:0] REG_HB_HI = 3'd1;
    localparam logic [2:0] REG_W2_0  = 3'd2;
    localparam logic [2:0] REG_W2_1  = 3'd3;
    localparam logic [2:0] REG_W2_2  = 3'd4;
    localparam logic [2:0] REG_W2_3  = 3'd5;
    localparam logic [2:0] REG_B2    = 3'd6;
    localparam logic [2:0] REG_OUT   = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACT1,
        ST_L2,
        ST_OUT,
        ST_SAT,
        ST_HOLD
    } qmlp_state_t;

    typedef struct packed {
        logic acc;
        logic act1;
        logic l2;
        logic [1:0] l2_idx;
        logic out;
        logic sat;
    } qmlp_cmd_t;

    // shift by ACT_SHIFT, ReLU, clamp to 0..ACT_MAX
    function automatic logic [6:0] activate(input logic signed [31:0] s);
        logic signed [31:0] r;
        begin
            r = s >>> ACT_SHIFT;
            if (s < 0)
                activate = 7'd0;
            else if (r > ACT_MAX)
                activate = 7'(ACT_MAX);
            else
                activate = r[6:0];
        end
    endfunction

endpackage

### rtl/qmlp_ctrl.sv
// ----------------------------------------------------------------------------
// qmlp_ctrl
// Sequencer: accumulates items, then steps through the evaluation.
// ----------------------------------------------------------------------------
module qmlp_ctrl
    import qmlp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_last,
    input  logic       out_stall,
    output logic       in_stall,
    output logic       out_valid,
    output qmlp_cmd_t  cmd
);

    qmlp_state_t state_reg, state_next;
    logic [1:0]  idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        cmd        = '0;
        cmd.l2_idx = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.acc = 1'b1;
                    if (in_last)
                        state_next = ST_ACT1;
                end
            end
            ST_ACT1:
            begin
                cmd.act1   = 1'b1;
                idx_next   = '0;
                state_next = ST_L2;
            end
            ST_L2:
            begin
                cmd.l2   = 1'b1;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'(N_HID2 - 1))
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                cmd.out    = 1'b1;
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                cmd.sat    = 1'b1;
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.acc, cmd.act1, cmd.l2, cmd.out, cmd.sat}))
        else $error("overlapping commands");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result held");
    a_last_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.acc && in_last) |=> cmd.act1)
        else $error("last beat did not start evaluation");

endmodule

### rtl/qmlp_dp.sv
// ----------------------------------------------------------------------------
// qmlp_dp
// Datapath: accumulators, layer activations, output dot product.
// ----------------------------------------------------------------------------
module qmlp_dp
    import qmlp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  qmlp_cmd_t          cmd,
    input  logic signed [15:0] input_value,
    input  logic [63:0]        w1_col,
    input  logic [63:0]        hb_lo,
    input  logic [63:0]        hb_hi,
    input  logic [255:0]       w2,
    input  logic [63:0]        b2,
    input  logic [47:0]        outp,
    output logic signed [15:0] score
);

    logic signed [SUM_BITS-1:0] sum_reg [N_HID1];
    logic [6:0]                 h1_reg  [N_HID1];
    logic [6:0]                 h2_reg  [N_HID2];
    logic signed [OUT_BITS-1:0] out_reg;
    logic signed [15:0]         score_reg;
    logic [6:0]                 x;
    logic signed [L2_BITS-1:0]  dot2;
    logic signed [OUT_BITS-1:0] dot3;
    logic [63:0]                w2_row;

    always_comb
    begin
        if (input_value < 0)
            x = 7'd0;
        else if (input_value > 16'sd127)
            x = 7'(ACT_MAX);
        else
            x = input_value[6:0];
    end

    assign w2_row = w2[64*cmd.l2_idx +: 64];

    always_comb
    begin
        dot2 = L2_BITS'(signed'(b2[16*cmd.l2_idx +: 16]));
        for (int k = 0; k < N_HID1; k++)
            dot2 = dot2 + L2_BITS'($signed({1'b0, h1_reg[k]})
                   * $signed(w2_row[8*k +: 8]));
        dot3 = OUT_BITS'(signed'(outp[47:32]));
        for (int k = 0; k < N_HID2; k++)
            dot3 = dot3 + OUT_BITS'($signed({1'b0, h2_reg[k]})
                   * $signed(outp[8*k +: 8]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < N_HID1; n++)
            begin
                sum_reg[n] <= '0;
                h1_reg[n]  <= '0;
            end
            for (int n = 0; n < N_HID2; n++)
                h2_reg[n] <= '0;
            out_reg   <= '0;
            score_reg <= '0;
        end
        else
        begin
            for (int n = 0; n < N_HID1; n++)
            begin
                if (cmd.acc)
                    sum_reg[n] <= sum_reg[n] + SUM_BITS'($signed({1'b0, x})
                                  * $signed(w1_col[8*n +: 8]));
                else if (cmd.act1)
                    sum_reg[n] <= '0;
                if (cmd.act1)
                    h1_reg[n] <= activate(32'(sum_reg[n]) + 32'(signed'(
                                 (n < 4) ? hb_lo[16*(n%4) +: 16] : hb_hi[16*(n%4) +: 16])));
            end
            if (cmd.l2)
                h2_reg[cmd.l2_idx] <= activate(32'(dot2));
            if (cmd.out)
                out_reg <= dot3;
            if (cmd.sat)
            begin
                if (out_reg > 32767)
                    score_reg <= 16'sh7fff;
                else if (out_reg < -32768)
                    score_reg <= 16'sh8000;
                else
                    score_reg <= out_reg[15:0];
            end
        end
    end

    assign score = score_reg;

endmodule

### rtl/quantized_mlp_8_8_4_1_eval.sv
// ----------------------------------------------------------------------------
// quantized_mlp_8_8_4_1_eval
// Quantized 8-8-4-1 network evaluator with APB register file.
//
//  channel | direction | handshake          | payload
//  in      | in        | in_valid/in_stall  | input_value, weight_to_hidden_0..7, last
//  out     | out       | out_valid/out_stall| score
//  apb     | in        | psel/penable/pready| paddr, pwdata, prdata (64 bit)
//
// Non-last beats are accepted back to back. A last beat is followed by
// evaluation (activation, four second-layer units, output, saturate) and
// the result is held until taken; input is stalled meanwhile.
// Reset clears registers and accumulators. No clearing pass.
// ----------------------------------------------------------------------------
module quantized_mlp_8_8_4_1_eval
    import qmlp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] input_value,
    input  logic signed [7:0]  weight_to_hidden_0,
    input  logic signed [7:0]  weight_to_hidden_1,
    input  logic signed [7:0]  weight_to_hidden_2,
    input  logic signed [7:0]  weight_to_hidden_3,
    input  logic signed [7:0]  weight_to_hidden_4,
    input  logic signed [7:0]  weight_to_hidden_5,
    input  logic signed [7:0]  weight_to_hidden_6,
    input  logic signed [7:0]  weight_to_hidden_7,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] score,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    logic [63:0] cfg_reg [8];
    logic        wr;
    logic [2:0]  ridx;
    qmlp_cmd_t   cmd;

    assign pready = 1'b1;
    assign ridx   = paddr[5:3];
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                cfg_reg[i] <= '0;
        end
        else if (wr)
        begin
            if (ridx == REG_OUT)
                cfg_reg[ridx] <= {16'd0, pwdata[47:0]};
            else
                cfg_reg[ridx] <= pwdata;
        end
    end

    assign prdata = cfg_reg[ridx];

    qmlp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (last),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    qmlp_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .input_value (input_value),
        .w1_col      ({weight_to_hidden_7, weight_to_hidden_6, weight_to_hidden_5,
                       weight_to_hidden_4, weight_to_hidden_3, weight_to_hidden_2,
                       weight_to_hidden_1, weight_to_hidden_0}),
        .hb_lo       (cfg_reg[REG_HB_LO]),
        .hb_hi       (cfg_reg[REG_HB_HI]),
        .w2          ({cfg_reg[REG_W2_3], cfg_reg[REG_W2_2],
                       cfg_reg[REG_W2_1], cfg_reg[REG_W2_0]}),
        .b2          (cfg_reg[REG_B2]),
        .outp        (cfg_reg[REG_OUT][47:0]),
        .score       (score)
    );

endmodule
